### hdl/esc_pkg.sv
// shared types, constants and register indexes of the sensor compensation block
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int DIV_STAGES = 64;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MISC_CALIB = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUMID_CAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_HUM    = 3'd5;

  localparam logic signed [31:0] T_FINE_P_OFS = 32'sd128000;
  localparam logic signed [31:0] T_FINE_H_OFS = 32'sd76800;
  localparam logic [63:0]        P_ADC_FULL   = 64'd1048576;
  localparam logic signed [63:0] P_SCALE      = 64'sd3125;
  localparam logic signed [31:0] H_ROUND      = 32'sd16384;
  localparam logic signed [31:0] H_G_OFS      = 32'sd2097152;
  localparam logic signed [31:0] H_MAX        = 32'sd419430400;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [47:0] misc;
    logic [31:0] hum;
    logic        has_hum;
  } calib_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        hval;
    logic        dzero;
    logic        qneg;
  } div_pl_t;

endpackage
`default_nettype wire

### hdl/esc_front.sv
// front pipeline: fine temperature, humidity and pressure numerator and divisor
`timescale 1ns / 1ps
`default_nettype none
module esc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_v,
  input  wire logic [19:0]     in_temp_adc,
  input  wire logic [19:0]     in_press_adc,
  input  wire logic [15:0]     in_hum_adc,
  input  wire esc_pkg::calib_t cal,
  output logic                 out_v,
  output logic [63:0]          out_num,
  output logic [63:0]          out_den,
  output esc_pkg::div_pl_t     out_pl
);
  import esc_pkg::*;

  logic [15:0] t1;
  logic signed [15:0] t2, t3;
  logic signed [63:0] p1, p2, p3, p4, p5, p6;
  logic signed [31:0] h1, h2, h3, h4s, h5, h6;

  assign t1  = cal.temp[15:0];
  assign t2  = $signed(cal.temp[31:16]);
  assign t3  = $signed(cal.temp[47:32]);
  assign p1  = $signed({48'b0, cal.press_lo[15:0]});
  assign p2  = 64'($signed(cal.press_lo[31:16]));
  assign p3  = 64'($signed(cal.press_lo[47:32]));
  assign p4  = 64'($signed(cal.press_lo[63:48]));
  assign p5  = 64'($signed(cal.press_hi[15:0]));
  assign p6  = 64'($signed(cal.press_hi[31:16]));
  assign h1  = $signed({24'b0, cal.misc[23:16]});
  assign h2  = 32'($signed(cal.misc[39:24]));
  assign h3  = $signed({24'b0, cal.misc[47:40]});
  assign h4s = $signed({cal.hum[11:0], 20'b0});
  assign h5  = $signed({20'b0, cal.hum[23:12]});
  assign h6  = 32'($signed(cal.hum[31:24]));

  logic [9:0] v_r;

  logic signed [18:0] x;
  logic signed [17:0] y;
  logic signed [34:0] s1_xa_r;
  logic signed [35:0] s1_yy_r;
  logic [19:0] s1_padc_r, s2_padc_r, s3_padc_r, s4_padc_r, s5_padc_r, s6_padc_r;
  logic [15:0] s1_hadc_r, s2_hadc_r, s3_hadc_r, s4_hadc_r;

  logic signed [23:0] s2_a_r;
  logic signed [35:0] yq;
  logic signed [39:0] s2_yt_r;

  logic signed [31:0] s3_tf_r;

  logic signed [63:0] d64;
  logic signed [31:0] hv;
  logic signed [31:0] s4_temp_r, s5_temp_r, s6_temp_r, s7_temp_r, s8_temp_r, s9_temp_r;
  logic signed [63:0] s4_dd_r, s4_dp5_r, s4_dp2_r;
  logic signed [31:0] s4_h6_r, s4_h3_r, s4_h5_r;

  logic signed [31:0] hx, hb, hc;
  logic signed [63:0] s5_e1_r, s5_ddp3_r, s5_dp5_r, s5_dp2_r;
  logic signed [31:0] s5_ha_r, s5_bc_r;

  logic signed [63:0] s6_e_r, s6_ds_r;
  logic signed [31:0] s6_ha_r, s6_gh_r;

  logic signed [63:0] nmb, s7_num_r, s7_m_r, s8_num_r, s8_dv_r;
  logic signed [31:0] hg, s7_ag_r, s8_ag_r, s9_ag_r, s8_ss_r, hs, s9_ssh_r;

  logic [63:0] s9_unum_r, s9_uden_r;
  logic        s9_qneg_r, s9_dzero_r;

  logic signed [31:0] hf;
  logic [16:0]        hq;
  logic [63:0]        s10_num_r, s10_den_r;
  div_pl_t            s10_pl_r;

  assign x   = $signed({2'b0, in_temp_adc[19:3]}) - $signed({2'b0, t1, 1'b0});
  assign y   = $signed({2'b0, in_temp_adc[19:4]}) - $signed({2'b0, t1});
  assign yq  = s1_yy_r >>> 12;
  assign d64 = 64'(s3_tf_r - T_FINE_P_OFS);
  assign hv  = s3_tf_r - T_FINE_H_OFS;
  assign hx  = $signed({2'b0, s4_hadc_r, 14'b0}) - h4s - s4_h5_r + H_ROUND;
  assign hb  = s4_h6_r >>> 10;
  assign hc  = (s4_h3_r >>> 11) + 32'sd32768;
  assign nmb = $signed((P_ADC_FULL - {44'b0, s6_padc_r}) << 31) - s6_e_r;
  assign hg  = (s6_gh_r + 32'sd8192) >>> 14;
  assign hs  = s7_ag_r >>> 15;

  always_comb begin
    hf = s9_ag_r - (s9_ssh_r >>> 4);
    if (hf[31]) begin
      hf = '0;
    end else if (hf > H_MAX) begin
      hf = H_MAX;
    end
    hq = hf[28:12];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[8:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xa_r   <= 35'(x) * 35'(t2);
      s1_yy_r   <= 36'(y) * 36'(y);
      s1_padc_r <= in_press_adc;
      s1_hadc_r <= in_hum_adc;

      s2_a_r    <= 24'(s1_xa_r >>> 11);
      s2_yt_r   <= 40'(yq[23:0]) * 40'(t3);
      s2_padc_r <= s1_padc_r;
      s2_hadc_r <= s1_hadc_r;

      s3_tf_r   <= 32'(s2_a_r) + 32'(s2_yt_r >>> 14);
      s3_padc_r <= s2_padc_r;
      s3_hadc_r <= s2_hadc_r;

      s4_temp_r <= s3_tf_r * 32'sd5 + 32'sd128;
      s4_dd_r   <= d64 * d64;
      s4_dp5_r  <= d64 * p5;
      s4_dp2_r  <= d64 * p2;
      s4_h6_r   <= hv * h6;
      s4_h3_r   <= hv * h3;
      s4_h5_r   <= h5 * hv;
      s4_padc_r <= s3_padc_r;
      s4_hadc_r <= s3_hadc_r;

      s5_e1_r   <= s4_dd_r * p6;
      s5_ddp3_r <= s4_dd_r * p3;
      s5_dp5_r  <= s4_dp5_r;
      s5_dp2_r  <= s4_dp2_r;
      s5_ha_r   <= hx >>> 15;
      s5_bc_r   <= hb * hc;
      s5_temp_r <= s4_temp_r;
      s5_padc_r <= s4_padc_r;

      s6_e_r    <= s5_e1_r + (s5_dp5_r <<< 17) + (p4 <<< 35);
      s6_ds_r   <= (s5_ddp3_r >>> 8) + (s5_dp2_r <<< 12);
      s6_ha_r   <= s5_ha_r;
      s6_gh_r   <= ((s5_bc_r >>> 10) + H_G_OFS) * h2;
      s6_temp_r <= s5_temp_r;
      s6_padc_r <= s5_padc_r;

      s7_num_r  <= nmb * P_SCALE;
      s7_m_r    <= ((64'sd1 <<< 47) + s6_ds_r) * p1;
      s7_ag_r   <= s6_ha_r * hg;
      s7_temp_r <= s6_temp_r;

      s8_num_r  <= s7_num_r;
      s8_dv_r   <= s7_m_r >>> 33;
      s8_ss_r   <= hs * hs;
      s8_ag_r   <= s7_ag_r;
      s8_temp_r <= s7_temp_r;

      s9_unum_r  <= s8_num_r[63] ? 64'(-s8_num_r) : 64'(s8_num_r);
      s9_uden_r  <= s8_dv_r[63] ? 64'(-s8_dv_r) : 64'(s8_dv_r);
      s9_qneg_r  <= s8_num_r[63] ^ s8_dv_r[63];
      s9_dzero_r <= (s8_dv_r == 64'sd0);
      s9_ssh_r   <= (s8_ss_r >>> 7) * h1;
      s9_ag_r    <= s8_ag_r;
      s9_temp_r  <= s8_temp_r;

      s10_num_r      <= s9_unum_r;
      s10_den_r      <= s9_uden_r;
      s10_pl_r.temp  <= s9_temp_r;
      s10_pl_r.hum   <= cal.has_hum ? hq : 17'd0;
      s10_pl_r.hval  <= cal.has_hum;
      s10_pl_r.dzero <= s9_dzero_r;
      s10_pl_r.qneg  <= s9_qneg_r;
    end
  end

  assign out_v   = v_r[9];
  assign out_num = s10_num_r;
  assign out_den = s10_den_r;
  assign out_pl  = s10_pl_r;

endmodule
`default_nettype wire

### hdl/esc_div.sv
// pipelined restoring divider, one quotient bit per stage, unsigned 64 by 64
`timescale 1ns / 1ps
`default_nettype none
module esc_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_v,
  input  wire logic [63:0]      in_num,
  input  wire logic [63:0]      in_den,
  input  wire esc_pkg::div_pl_t in_pl,
  output logic                  out_v,
  output logic [63:0]           out_quo,
  output esc_pkg::div_pl_t      out_pl
);
  import esc_pkg::*;

  logic [DIV_STAGES-1:0] v_r, v_p;
  logic [63:0]           a_r   [DIV_STAGES];
  logic [63:0]           rem_r [DIV_STAGES];
  logic [63:0]           den_r [DIV_STAGES];
  div_pl_t               pl_r  [DIV_STAGES];
  logic [63:0]           a_p   [DIV_STAGES];
  logic [63:0]           rem_p [DIV_STAGES];
  logic [63:0]           den_p [DIV_STAGES];
  div_pl_t               pl_p  [DIV_STAGES];
  logic [63:0]           a_nxt [DIV_STAGES];
  logic [63:0]           rem_nxt [DIV_STAGES];
  logic [64:0]           trial [DIV_STAGES];
  logic [64:0]           diff  [DIV_STAGES];
  logic [DIV_STAGES-1:0] ge;

  always_comb begin
    v_p[0]   = in_v;
    a_p[0]   = in_num;
    rem_p[0] = '0;
    den_p[0] = in_den;
    pl_p[0]  = in_pl;
    for (int k = 1; k < DIV_STAGES; k++) begin
      v_p[k]   = v_r[k-1];
      a_p[k]   = a_r[k-1];
      rem_p[k] = rem_r[k-1];
      den_p[k] = den_r[k-1];
      pl_p[k]  = pl_r[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      trial[k]   = {rem_p[k], a_p[k][63]};
      diff[k]    = trial[k] - {1'b0, den_p[k]};
      ge[k]      = (trial[k] >= {1'b0, den_p[k]});
      rem_nxt[k] = ge[k] ? diff[k][63:0] : trial[k][63:0];
      a_nxt[k]   = {a_p[k][62:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_p;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        a_r[k]   <= a_nxt[k];
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_p[k];
        pl_r[k]  <= pl_p[k];
      end
    end
  end

  assign out_v   = v_r[DIV_STAGES-1];
  assign out_quo = a_r[DIV_STAGES-1];
  assign out_pl  = pl_r[DIV_STAGES-1];

endmodule
`default_nettype wire

### hdl/env_sensor_compensation_top.sv
// top level: calibration registers, front pipeline, divider, pressure back end, output skid
//
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready   tdata: temp_adc, press_adc, hum_adc
// out_     out  out_tvalid/out_tready tdata: temperature, pressure, humidity; tuser: valid flag
// cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one sample per cycle while the skid is empty; registered through front pipeline, divider, back end and output
// the 64-stage divider, one quotient bit per stage, sets the depth
// rst_n synchronous active low clears valid bits and loads register defaults
// a stalled output fills a one-entry skid, then in_tready drops and the whole pipe holds
// cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none
module env_sensor_compensation_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [55:0]                   in_tdata,   // temp_adc, press_adc, hum_adc
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [87:0]                        out_tdata,  // temperature_scaled, pressure_q8, humidity_q10
  output logic                               out_tuser,  // humidity_valid
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [esc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                   cfg_data
);
  import esc_pkg::*;

  calib_t cal_r;
  logic   adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '{temp: '0, press_lo: '0, press_hi: '0, misc: '0, hum: '0, has_hum: 1'b1};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEMP_CALIB: cal_r.temp     <= cfg_data[47:0];
        REG_PRESS_LOW:  cal_r.press_lo <= cfg_data;
        REG_PRESS_HIGH: cal_r.press_hi <= cfg_data;
        REG_MISC_CALIB: cal_r.misc     <= cfg_data[47:0];
        REG_HUMID_CAL:  cal_r.hum      <= cfg_data[31:0];
        REG_HAS_HUM:    cal_r.has_hum  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic        f_v;
  logic [63:0] f_num, f_den;
  div_pl_t     f_pl;

  esc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_v         (in_tvalid && in_tready),
    .in_temp_adc  (in_tdata[19:0]),
    .in_press_adc (in_tdata[39:20]),
    .in_hum_adc   (in_tdata[55:40]),
    .cal          (cal_r),
    .out_v        (f_v),
    .out_num      (f_num),
    .out_den      (f_den),
    .out_pl       (f_pl)
  );

  logic        d_v;
  logic [63:0] d_quo;
  div_pl_t     d_pl;

  esc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (f_v),
    .in_num  (f_num),
    .in_den  (f_den),
    .in_pl   (f_pl),
    .out_v   (d_v),
    .out_quo (d_quo),
    .out_pl  (d_pl)
  );

  logic signed [63:0] p7, p8, p9, q, qs;
  assign p7 = 64'($signed(cal_r.press_hi[47:32]));
  assign p8 = 64'($signed(cal_r.press_hi[63:48]));
  assign p9 = 64'($signed(cal_r.misc[15:0]));
  assign q  = d_pl.qneg ? -$signed(d_quo) : $signed(d_quo);
  assign qs = q >>> 13;

  logic [3:0]         b_v_r;
  logic signed [63:0] b1_q_r, b1_s_r, b1_m_r, b1_pe_r;
  logic signed [63:0] b2_q_r, b2_pe_r;
  logic [63:0]        b2_ll_r;
  logic [31:0]        b2_cr_r;
  logic signed [63:0] b3_sum_r, prod, pfin;
  logic [31:0]        pclamp;
  div_pl_t            b1_pl_r, b2_pl_r, b3_pl_r;
  logic [31:0]        b4_temp_r, b4_press_r;
  logic [16:0]        b4_hum_r;
  logic               b4_hval_r;

  assign prod = $signed(b2_ll_r + {b2_cr_r, 32'b0});
  assign pfin = (b3_sum_r >>> 8) + (p7 <<< 4);

  always_comb begin
    if (b3_pl_r.dzero || pfin[63]) begin
      pclamp = '0;
    end else if (pfin[62:32] != '0) begin
      pclamp = '1;
    end else begin
      pclamp = pfin[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= '0;
    end else if (adv) begin
      b_v_r <= {b_v_r[2:0], d_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_q_r   <= q;
      b1_s_r   <= qs;
      b1_m_r   <= p9 * qs;
      b1_pe_r  <= p8 * q;
      b1_pl_r  <= d_pl;

      b2_ll_r  <= {32'b0, b1_m_r[31:0]} * {32'b0, b1_s_r[31:0]};
      b2_cr_r  <= 32'(b1_m_r[31:0] * b1_s_r[63:32]) + 32'(b1_m_r[63:32] * b1_s_r[31:0]);
      b2_q_r   <= b1_q_r;
      b2_pe_r  <= b1_pe_r;
      b2_pl_r  <= b1_pl_r;

      b3_sum_r <= b2_q_r + (prod >>> 25) + (b2_pe_r >>> 19);
      b3_pl_r  <= b2_pl_r;

      b4_temp_r  <= b3_pl_r.temp;
      b4_press_r <= pclamp;
      b4_hum_r   <= b3_pl_r.hum;
      b4_hval_r  <= b3_pl_r.hval;
    end
  end

  // output register with one-entry skid
  logic        out_valid_r, skid_valid_r, push, pop;
  logic [81:0] out_data_r, skid_data_r, push_data;

  assign adv       = !skid_valid_r;
  assign in_tready = adv;
  assign push      = adv && b_v_r[3];
  assign pop       = out_valid_r && out_tready;
  assign push_data = {b4_hval_r, b4_hum_r, b4_press_r, b4_temp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_valid_r || pop) begin
      out_data_r <= push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_data_r[80:0]};
  assign out_tuser  = out_data_r[81];

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid holds data while output empty");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !in_tready) else $error("input taken while skid full");

  a_push_into_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_tready && !skid_valid_r) |=> skid_valid_r)
    else $error("stalled transfer not captured in skid");

  a_hum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[80:64] == 17'd0))
    else $error("humidity nonzero without humidity_valid");

endmodule
`default_nettype wire

### tb/tb.sv
// self-checking testbench for the sensor compensation block with a built-in integer predictor
`timescale 1ns / 1ps
module tb;
  import esc_pkg::*;

  typedef struct {
    logic [19:0] temp_adc;
    logic [19:0] press_adc;
    logic [15:0] hum_adc;
  } sample_t;

  typedef struct {
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic [16:0]        humidity;
    logic               hum_valid;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [47:0] cal_temp = '0;
  logic [63:0] cal_press_lo = '0;
  logic [63:0] cal_press_hi = '0;
  logic [47:0] cal_misc = '0;
  logic [31:0] cal_hum = '0;
  logic        cal_has_hum = 1'b1;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int  errors = 0;
  int  samples_sent = 0;
  int  readings_checked = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_count = 0;
  bit  quiet = 1'b0;
  bit  long_hold = 1'b0;
  bit  hold_done = 1'b0;

  env_sensor_compensation_top i_dut (.*);

  always #6 clk = ~clk;

  function automatic reading_t compensate(sample_t s);
    logic signed [63:0] t1, t2, t3, x, a, y, b, tf;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, d, e, p, num, dd;
    logic [63:0] ua, ub, q;
    logic signed [31:0] h1, h2, h3, h4, h5, h6, hadc, v, ha, hb, hc, g, hs;
    reading_t r;
    t1 = {48'd0, cal_temp[15:0]};
    t2 = $signed(cal_temp[31:16]);
    t3 = $signed(cal_temp[47:32]);
    x = {47'd0, s.temp_adc[19:3]} - (t1 <<< 1);
    a = (x * t2) >>> 11;
    y = {48'd0, s.temp_adc[19:4]} - t1;
    b = (((y * y) >>> 12) * t3) >>> 14;
    tf = a + b;
    r.temperature = 32'(tf * 64'sd5 + 64'sd128);

    p1 = {48'd0, cal_press_lo[15:0]};
    p2 = $signed(cal_press_lo[31:16]);
    p3 = $signed(cal_press_lo[47:32]);
    p4 = $signed(cal_press_lo[63:48]);
    p5 = $signed(cal_press_hi[15:0]);
    p6 = $signed(cal_press_hi[31:16]);
    p7 = $signed(cal_press_hi[47:32]);
    p8 = $signed(cal_press_hi[63:48]);
    p9 = $signed(cal_misc[15:0]);
    d = tf - 64'sd128000;
    e = d * d * p6;
    e = e + ((d * p5) <<< 17);
    e = e + (p4 <<< 35);
    d = ((d * d * p3) >>> 8) + ((d * p2) <<< 12);
    d = ((64'sh0000_8000_0000_0000 + d) * p1) >>> 33;
    if (d == 0) begin
      r.pressure = '0;
    end else begin
      p = 64'sd1048576 - {44'd0, s.press_adc};
      num = ((p <<< 31) - e) * 64'sd3125;
      ua = num[63] ? -num : num;
      ub = d[63] ? -d : d;
      q = ua / ub;
      p = (num[63] ^ d[63]) ? -q : q;
      dd = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      e = (p8 * p) >>> 19;
      p = ((p + dd + e) >>> 8) + (p7 <<< 4);
      if (p < 0) r.pressure = '0;
      else if (p > 64'sd4294967295) r.pressure = '1;
      else r.pressure = p[31:0];
    end

    if (cal_has_hum) begin
      h1 = {24'd0, cal_misc[23:16]};
      h2 = $signed(cal_misc[39:24]);
      h3 = {24'd0, cal_misc[47:40]};
      h4 = {20'd0, cal_hum[11:0]};
      h5 = {20'd0, cal_hum[23:12]};
      h6 = $signed(cal_hum[31:24]);
      hadc = {16'd0, s.hum_adc};
      v = tf[31:0] - 32'sd76800;
      ha = ((hadc <<< 14) - (h4 <<< 20) - h5 * v + 32'sd16384) >>> 15;
      hb = (v * h6) >>> 10;
      hc = ((v * h3) >>> 11) + 32'sd32768;
      g = ((hb * hc) >>> 10) + 32'sd2097152;
      g = (g * h2 + 32'sd8192) >>> 14;
      v = ha * g;
      hs = v >>> 15;
      v = v - ((((hs * hs) >>> 7) * h1) >>> 4);
      if (v < 0) v = 0;
      if (v > 32'sd419430400) v = 32'sd419430400;
      v = v >>> 12;
      r.humidity = v[16:0];
      r.hum_valid = 1'b1;
    end else begin
      r.humidity = '0;
      r.hum_valid = 1'b0;
    end
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_readings.insert(expected_readings.size(), compensate(pending_samples[0]));
        pending_samples.pop_front();
        samples_sent++;
      end
      if (send_gap > 0) begin
        send_gap--;
      end else if (!quiet && !(in_tvalid && !in_tready) && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 4);
      end
      if (pending_samples.size() > 0 && send_gap == 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_samples[0].hum_adc, pending_samples[0].press_adc,
                     pending_samples[0].temp_adc};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    reading_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected transfer on output: %h", out_tdata);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          if (out_tdata[31:0] !== want.temperature) begin
            $error("temperature_scaled expected %0d got %0d", want.temperature,
                   $signed(out_tdata[31:0]));
            errors++;
          end
          if (out_tdata[63:32] !== want.pressure) begin
            $error("pressure_q8 expected %0d got %0d", want.pressure, out_tdata[63:32]);
            errors++;
          end
          if (out_tdata[80:64] !== want.humidity) begin
            $error("humidity_q10 expected %0d got %0d", want.humidity, out_tdata[80:64]);
            errors++;
          end
          if (out_tuser !== want.hum_valid) begin
            $error("humidity_valid expected %0d got %0d", want.hum_valid, out_tuser);
            errors++;
          end
        end
      end
      if (long_hold && !hold_done) begin
        hold_count++;
        if (hold_count >= 300) hold_done = 1'b1;
        out_tready <= 1'b0;
      end else begin
        if (recv_gap > 0) begin
          recv_gap--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          recv_gap = $urandom_range(1, 4);
        end
        out_tready <= (recv_gap == 0);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TEMP_CALIB: cal_temp = value[47:0];
      REG_PRESS_LOW:  cal_press_lo = value;
      REG_PRESS_HIGH: cal_press_hi = value;
      REG_MISC_CALIB: cal_misc = value[47:0];
      REG_HUMID_CAL:  cal_hum = value[31:0];
      REG_HAS_HUM:    cal_has_hum = value[0];
      default: ;
    endcase
  endtask

  task automatic load_calib(logic [47:0] tc, logic [63:0] plo, logic [63:0] phi,
                            logic [47:0] mc, logic [31:0] hc, logic hh);
    write_reg(REG_TEMP_CALIB, {16'd0, tc});
    write_reg(REG_PRESS_LOW, plo);
    write_reg(REG_PRESS_HIGH, phi);
    write_reg(REG_MISC_CALIB, {16'd0, mc});
    write_reg(REG_HUMID_CAL, {32'd0, hc});
    write_reg(REG_HAS_HUM, {63'd0, hh});
  endtask

  task automatic load_typical(logic hh);
    load_calib({16'(-1000), 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'(-10685), 16'd36477},
               {16'(-14600), 16'd15500, 16'(-7), 16'd140},
               {8'd0, 16'd362, 8'd75, 16'd6000},
               {8'd30, 12'd50, 12'd313}, hh);
  endtask

  task automatic load_random(logic hh);
    load_calib(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
               48'({$urandom, $urandom}), $urandom, hh);
  endtask

  task automatic add(logic [19:0] t, logic [19:0] p, logic [15:0] h);
    sample_t s;
    s.temp_adc = t;
    s.press_adc = p;
    s.hum_adc = h;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  task automatic add_directed();
    add(20'd0, 20'd0, 16'd0);
    add(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    add(20'd519888, 20'd415148, 16'd30000);
    add(20'd0, 20'd415148, 16'hFFFF);
    add(20'hFFFFF, 20'd0, 16'd0);
    add(20'd300000, 20'd250000, 16'd20000);
    add(20'd700000, 20'd600000, 16'd45000);
    add(20'h55555, 20'hAAAAA, 16'h5A5A);
  endtask

  task automatic add_random(int n);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0, 1: add(20'($urandom), 20'($urandom), 16'($urandom));
        2: add(20'($urandom_range(450000, 580000)), 20'($urandom_range(250000, 500000)),
               16'($urandom_range(15000, 50000)));
        default: add($urandom_range(0, 1) ? 20'hFFFFF : 20'd0, 20'($urandom),
                     $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 400)));
      endcase
    end
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || expected_readings.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // reset calibration: divisor is zero
    add_directed();
    drain();
    load_typical(1'b1);
    add_directed();
    add_random(200);
    drain();
    load_calib('1, '1, '1, '1, '1, 1'b1);
    add_directed();
    add_random(40);
    drain();
    load_random(1'b0);
    add_random(150);
    drain();
    load_calib('0, {48'd0, 16'hFFFF}, '0, '0, '0, 1'b1);
    add_random(30);
    drain();
    // receiver holds off while samples keep coming
    load_typical(1'b1);
    long_hold = 1'b1;
    add_random(250);
    drain();
    load_random(1'b1);
    quiet = 1'b1;
    add_random(200);
    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d samples, %0d results checked across reset, typical, extreme,",
             samples_sent, readings_checked);
    $display("random and pressure-only calibrations, with a long output stall");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
